// ===== src/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants for the tilt, speed and dash detector
// Register indexes, reset values, divide-by-ten constants and the config
// bundle handed from the top level to the dash tracker.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_DZ_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DASH_RUN_LENGTH = 2'd1;

  localparam int DZ_THR_W = 10;
  localparam int RUN_W    = 4;

  localparam logic [DZ_THR_W-1:0] DZ_THRESHOLD_RST    = 10'd200;
  localparam logic [RUN_W-1:0]    DASH_RUN_LENGTH_RST = 4'd3;
  localparam logic [RUN_W-1:0]    RUN_MAX             = 4'd15;

  // Result field widths
  localparam int FILT_W  = 9;
  localparam int SPEED_W = 5;

  // Speed code: nibble above SPEED_LIMIT gets SPEED_ADJ added
  localparam logic [3:0] SPEED_LIMIT = 4'd9;
  localparam logic [3:0] SPEED_ADJ   = 4'd6;

  // floor(p/10) = floor(p * DIV10_MUL / 2^DIV10_SHIFT), low by at most one
  localparam int          DIV10_MUL_W = 21;
  localparam logic [20:0] DIV10_MUL   = 21'd1677721;
  localparam int          DIV10_SHIFT = 24;
  localparam int          DIV10_BASE  = 10;

  typedef struct packed {
    logic [DZ_THR_W-1:0] dz_threshold;
    logic [RUN_W-1:0]    dash_run_length;
  } cfg_t;

endpackage

// ===== src/tsd_div10.sv =====
// ----------------------------------------------------------------------------
// tsd_div10: unsigned divide by ten
// Reciprocal multiply gives a quotient at most one low; a single
// compare of the remainder fixes it up.
// ----------------------------------------------------------------------------
module tsd_div10 #(
  parameter int W = 12
) (
  input  logic [W-1:0] p,
  output logic [W-1:0] q
);

  localparam int PROD_W = W + tsd_pkg::DIV10_MUL_W;

  logic [PROD_W-1:0] prod;
  logic [W-1:0]      q0;
  logic [W-1:0]      rem;

  // Estimate by reciprocal
  assign prod = PROD_W'(p) * PROD_W'(tsd_pkg::DIV10_MUL);
  assign q0   = W'(prod >> tsd_pkg::DIV10_SHIFT);

  // Remainder check: q0*10 = q0*8 + q0*2, never above p
  assign rem = p - ((q0 << 3) + (q0 << 1));
  assign q   = (rem >= W'(tsd_pkg::DIV10_BASE)) ? q0 + W'(1) : q0;

endmodule

// ===== src/tsd_fir.sv =====
// ----------------------------------------------------------------------------
// tsd_fir: x magnitude history and weighted tenths filter
// Holds three past magnitudes, forms the 4/3/2/1 weighted sum of
// truncated tenths, and derives tilt direction and speed code.
// ----------------------------------------------------------------------------
module tsd_fir #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic signed [SAMPLE_BITS-1:0]      x_sample,
  output logic                               tilt_right,
  output logic [tsd_pkg::FILT_W-1:0]         filtered_magnitude,
  output logic [tsd_pkg::SPEED_W-1:0]        speed_code
);

  // 4*m needs two bits over the magnitude
  localparam int PW = SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] hist_r   [3];
  logic [SAMPLE_BITS-1:0] hist_nxt [3];
  logic [PW-1:0]          term [4];
  logic [PW-1:0]          tenth [4];
  logic [PW-1:0]          sum;
  logic [3:0]             nib;

  // Magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1)
  assign tilt_right = x_sample[SAMPLE_BITS-1];
  assign mag = tilt_right ? (~x_sample + SAMPLE_BITS'(1)) : x_sample;

  // Weighted taps, newest first
  assign term[0] = PW'(mag) << 2;
  assign term[1] = (PW'(hist_r[0]) << 1) + PW'(hist_r[0]);
  assign term[2] = PW'(hist_r[1]) << 1;
  assign term[3] = PW'(hist_r[2]);

  for (genvar i = 0; i < 4; i++) begin : g_tap
    tsd_div10 #(.W(PW)) u_div10 (
      .p (term[i]),
      .q (tenth[i])
    );
  end

  assign sum = tenth[0] + tenth[1] + tenth[2] + tenth[3];
  assign filtered_magnitude = sum[tsd_pkg::FILT_W-1:0];

  // Speed code from bits 7:4
  assign nib = sum[7:4];
  assign speed_code = (nib > tsd_pkg::SPEED_LIMIT)
                    ? ({1'b0, nib} + {1'b0, tsd_pkg::SPEED_ADJ})
                    : {1'b0, nib};

  // History shift on each accepted item
  always_comb begin
    hist_nxt[0] = hist_r[0];
    hist_nxt[1] = hist_r[1];
    hist_nxt[2] = hist_r[2];
    if (advance) begin
      hist_nxt[0] = mag;
      hist_nxt[1] = hist_r[0];
      hist_nxt[2] = hist_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0] <= '0;
      hist_r[1] <= '0;
      hist_r[2] <= '0;
    end else begin
      hist_r[0] <= hist_nxt[0];
      hist_r[1] <= hist_nxt[1];
      hist_r[2] <= hist_nxt[2];
    end
  end

endmodule

// ===== src/tsd_dash.sv =====
// ----------------------------------------------------------------------------
// tsd_dash: z rise run tracker
// Compares each z change against the threshold, keeps a saturating run
// of large rises and flags a dash once the run reaches the set length.
// ----------------------------------------------------------------------------
module tsd_dash #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic signed [SAMPLE_BITS-1:0] z_sample,
  input  tsd_pkg::cfg_t                 cfg,
  output logic                          dashing,
  output logic [tsd_pkg::RUN_W-1:0]     run_count
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CMP_W  = (DIFF_W > tsd_pkg::DZ_THR_W + 1) ? DIFF_W
                                                           : tsd_pkg::DZ_THR_W + 1;

  logic [SAMPLE_BITS-1:0]        last_z_r, last_z_nxt;
  logic [tsd_pkg::RUN_W-1:0]     run_r, run_nxt;
  logic signed [DIFF_W-1:0]      dz;
  logic signed [CMP_W-1:0]       dz_ext;
  logic signed [CMP_W-1:0]       thr_ext;
  logic                          exceed;
  logic [tsd_pkg::RUN_W-1:0]     run_inc;

  // Signed z change, widened for a compare against the unsigned threshold
  assign dz      = signed'({z_sample[SAMPLE_BITS-1], z_sample})
                 - signed'({last_z_r[SAMPLE_BITS-1], last_z_r});
  assign dz_ext  = CMP_W'(dz);
  assign thr_ext = signed'({{(CMP_W - tsd_pkg::DZ_THR_W){1'b0}}, cfg.dz_threshold});
  assign exceed  = dz_ext > thr_ext;

  // Saturating run; any non-exceeding change clears it
  assign run_inc = (run_r == tsd_pkg::RUN_MAX) ? run_r : run_r + tsd_pkg::RUN_W'(1);
  assign dashing = exceed && (run_inc >= cfg.dash_run_length);

  always_comb begin
    run_nxt    = run_r;
    last_z_nxt = last_z_r;
    if (advance) begin
      run_nxt    = exceed ? run_inc : '0;
      last_z_nxt = z_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_z_r <= '0;
      run_r    <= '0;
    end else begin
      last_z_r <= last_z_nxt;
      run_r    <= run_nxt;
    end
  end

  assign run_count = run_r;

endmodule

// ===== src/tilt_speed_and_dash_detector_top.sv =====
// ----------------------------------------------------------------------------
// tilt_speed_and_dash_detector_top: accelerometer tilt, speed and dash flags
// Each (x, z) sample item yields one result item: tilt direction, weighted
// x magnitude, speed code and dash flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_x_sample and in_z_sample.
//   Result channel out_valid/out_ready carries tilt_right,
//   filtered_magnitude, speed_code and dashing.
//   cfg_we/cfg_index/cfg_wdata write dz_threshold (index 0) and
//   dash_run_length (index 1); other indexes are ignored. Write only idle.
// Timing:
//   An item accepted at edge N is shown on the output from edge N.
//   Throughput is one item per cycle unless stalled; the whole computation
//   (four divide-by-ten reciprocal multiplies and one add tree) sits between
//   the input ports plus history/run registers and the output register.
//   in_ready is high while the output register is empty or being taken, so
//   a new item enters in the same cycle the previous result leaves.
// Reset:
//   Synchronous active-low rst_n clears the history, last z, run count and
//   output valid, and loads the register reset values (200 and 3).
// Stall:
//   While out_valid is high and out_ready low, the result holds and
//   in_ready is low; no state advances.
// ----------------------------------------------------------------------------
module tilt_speed_and_dash_detector_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [tsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_x_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_z_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_tilt_right,
  output logic [tsd_pkg::FILT_W-1:0]          out_filtered_magnitude,
  output logic [tsd_pkg::SPEED_W-1:0]         out_speed_code,
  output logic                                out_dashing
);

  tsd_pkg::cfg_t                 cfg_r, cfg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          tilt_r;
  logic [tsd_pkg::FILT_W-1:0]    filt_r;
  logic [tsd_pkg::SPEED_W-1:0]   speed_r;
  logic                          dash_r;
  logic                          in_accept;
  logic                          tilt_c;
  logic [tsd_pkg::FILT_W-1:0]    filt_c;
  logic [tsd_pkg::SPEED_W-1:0]   speed_c;
  logic                          dash_c;
  logic [tsd_pkg::RUN_W-1:0]     run_count;

  // Handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Config register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tsd_pkg::CFG_DZ_THRESHOLD:
          cfg_nxt.dz_threshold = cfg_wdata[tsd_pkg::DZ_THR_W-1:0];
        tsd_pkg::CFG_DASH_RUN_LENGTH:
          cfg_nxt.dash_run_length = cfg_wdata[tsd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_threshold    <= tsd_pkg::DZ_THRESHOLD_RST;
      cfg_r.dash_run_length <= tsd_pkg::DASH_RUN_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Datapath
  tsd_fir #(.SAMPLE_BITS(SAMPLE_BITS)) u_fir (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (in_accept),
    .x_sample           (in_x_sample),
    .tilt_right         (tilt_c),
    .filtered_magnitude (filt_c),
    .speed_code         (speed_c)
  );

  tsd_dash #(.SAMPLE_BITS(SAMPLE_BITS)) u_dash (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_accept),
    .z_sample  (in_z_sample),
    .cfg       (cfg_r),
    .dashing   (dash_c),
    .run_count (run_count)
  );

  // Output register
  assign out_valid_nxt = in_accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tilt_r  <= tilt_c;
      filt_r  <= filt_c;
      speed_r <= speed_c;
      dash_r  <= dash_c;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_tilt_right         = tilt_r;
  assign out_filtered_magnitude = filt_r;
  assign out_speed_code         = speed_r;
  assign out_dashing            = dash_r;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && out_valid_r && !out_ready))
    else $error("item accepted over a stalled result");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item gave no result");

  a_speed_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_speed_code >= 5'd10 && out_speed_code <= 5'd15))
    else $error("speed code in skipped range");

  a_dash_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dashing) |-> (run_count != '0))
    else $error("dash flagged with empty run");

endmodule

// ===== tb/sv/tsd_result_checker.sv =====
// ----------------------------------------------------------------------------
// tsd_result_checker: result predictor and scoreboard for the tilt detector
// Watches the config port and both item channels, computes the expected
// tilt, filtered magnitude, speed code and dash flag for every accepted
// sample item and compares each accepted result item against the oldest one.
// ----------------------------------------------------------------------------
module tsd_result_checker #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_x_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_z_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_tilt_right,
  input  logic [tsd_pkg::FILT_W-1:0]          out_filtered_magnitude,
  input  logic [tsd_pkg::SPEED_W-1:0]         out_speed_code,
  input  logic                                out_dashing,
  output int                                  fail_count,
  output int                                  outstanding
);

  typedef struct packed {
    logic                        tilt_right;
    logic [tsd_pkg::FILT_W-1:0]  filtered_magnitude;
    logic [tsd_pkg::SPEED_W-1:0] speed_code;
    logic                        dashing;
  } motion_result_t;

  motion_result_t expected_q[$];

  // shadow of the block's registers and state
  logic [tsd_pkg::DZ_THR_W-1:0]  dz_thr;
  logic [tsd_pkg::RUN_W-1:0]     run_len;
  logic [SAMPLE_BITS-1:0]        mag_hist[3];
  logic signed [SAMPLE_BITS-1:0] prev_z;
  logic [tsd_pkg::RUN_W-1:0]     rise_run;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Compute one result and advance the shadow state
  task automatic predict_motion(input logic signed [SAMPLE_BITS-1:0] x,
                                input logic signed [SAMPLE_BITS-1:0] z,
                                output motion_result_t res);
    int         mag;
    int         sum;
    int         dz;
    logic [3:0] nib;
    mag = (x < 0) ? -int'(x) : int'(x);
    // per-tap truncated tenths, weights 4,3,2,1 newest to oldest
    sum = (4 * mag) / tsd_pkg::DIV10_BASE
        + (3 * int'(mag_hist[0])) / tsd_pkg::DIV10_BASE
        + (2 * int'(mag_hist[1])) / tsd_pkg::DIV10_BASE
        + int'(mag_hist[2]) / tsd_pkg::DIV10_BASE;
    mag_hist[2] = mag_hist[1];
    mag_hist[1] = mag_hist[0];
    mag_hist[0] = mag[SAMPLE_BITS-1:0];

    res.tilt_right         = (x < 0);
    res.filtered_magnitude = sum[tsd_pkg::FILT_W-1:0];
    nib = sum[7:4];
    res.speed_code = (nib > tsd_pkg::SPEED_LIMIT)
                   ? {1'b0, nib} + {1'b0, tsd_pkg::SPEED_ADJ}
                   : {1'b0, nib};

    // run of large z rises; anything at or below threshold clears it
    dz = int'(z) - int'(prev_z);
    if (dz > int'(dz_thr)) begin
      if (rise_run != tsd_pkg::RUN_MAX) rise_run = rise_run + tsd_pkg::RUN_W'(1);
      res.dashing = (rise_run >= run_len);
    end else begin
      rise_run    = '0;
      res.dashing = 1'b0;
    end
    prev_z = z;
  endtask

  task automatic flag_field(input string field, input logic [tsd_pkg::FILT_W-1:0] want,
                            input logic [tsd_pkg::FILT_W-1:0] seen);
    $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, want, seen);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    motion_result_t exp_r;
    motion_result_t got_r;
    if (!rst_n) begin
      dz_thr   = tsd_pkg::DZ_THRESHOLD_RST;
      run_len  = tsd_pkg::DASH_RUN_LENGTH_RST;
      mag_hist = '{default: '0};
      prev_z   = '0;
      rise_run = '0;
      expected_q.delete();
    end else begin
      // register writes, unknown indexes ignored
      if (cfg_we) begin
        case (cfg_index)
          tsd_pkg::CFG_DZ_THRESHOLD:
            dz_thr  = cfg_wdata[tsd_pkg::DZ_THR_W-1:0];
          tsd_pkg::CFG_DASH_RUN_LENGTH:
            run_len = cfg_wdata[tsd_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid && out_ready) begin
        got_r = '{out_tilt_right, out_filtered_magnitude, out_speed_code, out_dashing};
        if (expected_q.size() == 0) begin
          $display("%0t: result with none pending, expected nothing actual %h",
                   $realtime, got_r);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.tilt_right !== exp_r.tilt_right)
            flag_field("tilt_right", tsd_pkg::FILT_W'(exp_r.tilt_right),
                       tsd_pkg::FILT_W'(got_r.tilt_right));
          if (got_r.filtered_magnitude !== exp_r.filtered_magnitude)
            flag_field("filtered_magnitude", exp_r.filtered_magnitude,
                       got_r.filtered_magnitude);
          if (got_r.speed_code !== exp_r.speed_code)
            flag_field("speed_code", tsd_pkg::FILT_W'(exp_r.speed_code),
                       tsd_pkg::FILT_W'(got_r.speed_code));
          if (got_r.dashing !== exp_r.dashing)
            flag_field("dashing", tsd_pkg::FILT_W'(exp_r.dashing),
                       tsd_pkg::FILT_W'(got_r.dashing));
        end
      end
      if (in_valid && in_ready) begin
        predict_motion(in_x_sample, in_z_sample, exp_r);
        expected_q.push_back(exp_r);
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_tilt_speed_and_dash_detector_top.sv =====
// ----------------------------------------------------------------------------
// tb_tilt_speed_and_dash_detector_top: stimulus and verdict for the detector
// Drives a directed set of sample items at the register extremes, then
// random phases of rising-z runs and noise under changing thresholds and run
// lengths, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_tilt_speed_and_dash_detector_top;

  localparam int SAMPLE_BITS  = 10;
  localparam int SAMPLE_MIN   = -512;
  localparam int SAMPLE_MAX   = 511;
  localparam int DZ_MAX       = 1023;
  localparam int RUN_TOP      = int'(tsd_pkg::RUN_MAX);
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;

  // indexes with no register behind them
  localparam logic [tsd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tsd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [tsd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tsd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic signed [SAMPLE_BITS-1:0]   in_x_sample = '0;
  logic signed [SAMPLE_BITS-1:0]   in_z_sample = '0;
  logic                            out_ready = 1'b0;
  logic                            in_ready;
  logic                            out_valid;
  logic                            out_tilt_right;
  logic [tsd_pkg::FILT_W-1:0]      out_filtered_magnitude;
  logic [tsd_pkg::SPEED_W-1:0]     out_speed_code;
  logic                            out_dashing;

  int mismatches;
  int outstanding;

  // stimulus-side view of the current setting and last z sent
  int thr_now     = int'(tsd_pkg::DZ_THRESHOLD_RST);
  int last_sent_z = 0;
  bit send_idle   = 1'b1;

  tilt_speed_and_dash_detector_top #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_x_sample            (in_x_sample),
    .in_z_sample            (in_z_sample),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_tilt_right         (out_tilt_right),
    .out_filtered_magnitude (out_filtered_magnitude),
    .out_speed_code         (out_speed_code),
    .out_dashing            (out_dashing)
  );

  tsd_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_x_sample            (in_x_sample),
    .in_z_sample            (in_z_sample),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_tilt_right         (out_tilt_right),
    .out_filtered_magnitude (out_filtered_magnitude),
    .out_speed_code         (out_speed_code),
    .out_dashing            (out_dashing),
    .fail_count             (mismatches),
    .outstanding            (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one sample item; valid stays up across back-to-back items
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x,
                             input logic [SAMPLE_BITS-1:0] z);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_x_sample <= x;
    in_z_sample <= z;
    do @(posedge clk); while (!in_ready);
    last_sent_z = int'(signed'(z));
  endtask

  // Mostly rising z runs just over the threshold, some exact-threshold
  // changes, the rest noise; x leans on its extremes now and then
  task automatic send_random_sample();
    int r;
    int xi;
    int zi;
    r = $urandom_range(0, 99);
    if (r < 65 && thr_now < DZ_MAX) begin
      zi = last_sent_z + thr_now + 1 + $urandom_range(0, 40);
      if (zi > SAMPLE_MAX) zi = SAMPLE_MIN + $urandom_range(0, 63);
    end else if (r < 75 && last_sent_z + thr_now <= SAMPLE_MAX) begin
      zi = last_sent_z + thr_now;
    end else begin
      zi = $urandom_range(0, 1023);
    end
    case ($urandom_range(0, 9))
      0:       xi = SAMPLE_MIN;
      1:       xi = SAMPLE_MAX;
      2:       xi = $urandom_range(0, 20) - 10;
      default: xi = $urandom_range(0, 1023);
    endcase
    send_sample(xi[SAMPLE_BITS-1:0], zi[SAMPLE_BITS-1:0]);
  endtask

  // Wait until every result is back; ends on a rising edge
  task automatic wait_drained();
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Threshold, run length (junk in the upper bits), then a spare index
  task automatic program_cfg(input int thr, input int len);
    int junk;
    junk = $urandom_range(0, 63);
    cfg_we    <= 1'b1;
    cfg_index <= tsd_pkg::CFG_DZ_THRESHOLD;
    cfg_wdata <= thr[tsd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= tsd_pkg::CFG_DASH_RUN_LENGTH;
    cfg_wdata <= tsd_pkg::CFG_DATA_W'({junk, len[tsd_pkg::RUN_W-1:0]});
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_wdata <= tsd_pkg::CFG_DATA_W'($urandom_range(0, 1023));
    @(posedge clk);
    cfg_we  <= 1'b0;
    thr_now = thr;
  endtask

  // Result side: random stalls in stretches, one long hold-off
  initial begin
    int gap;
    int taken;
    bit rcv_idle;
    taken    = 0;
    rcv_idle = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) rcv_idle = ($urandom_range(0, 1) != 0);
      gap = rcv_idle ? $urandom_range(0, 19) : 0;
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int sent;
    int phase;
    int n;
    sent  = 0;
    phase = 0;
    wait (rst_n);
    @(posedge clk);

    // reset setting: threshold 200, run length 3
    send_sample(10'sd0,    10'sd0);
    send_sample(-10'sd512, 10'sd200);    // change equal to threshold
    send_sample(-10'sd512, 10'sd401);    // just over
    send_sample(-10'sd512, -10'sd512);   // negative change clears
    send_sample(-10'sd512, -10'sd300);
    send_sample(10'sd511,  -10'sd90);
    send_sample(10'sd511,  10'sd120);    // run reaches length
    send_sample(-10'sd1,   10'sd330);
    send_sample(10'sd1,    10'sd511);
    send_sample(10'sd0,    -10'sd512);
    send_sample(-10'sd512, 10'sd511);    // largest rise
    send_sample(10'sd511,  10'sd511);    // no change
    send_sample(10'sd7,    10'sd0);
    send_sample(-10'sd13,  -10'sd5);
    in_valid <= 1'b0;
    wait_drained();

    // zero threshold, zero run length: every rise dashes
    program_cfg(0, 0);
    send_sample(10'sd3,    10'sd1);
    send_sample(10'sd3,    10'sd2);
    send_sample(-10'sd3,   10'sd3);
    send_sample(10'sd3,    10'sd3);
    send_sample(-10'sd300, -10'sd512);
    send_sample(10'sd300,  10'sd511);
    in_valid <= 1'b0;
    wait_drained();

    // top threshold: nothing can exceed it
    program_cfg(DZ_MAX, RUN_TOP);
    send_sample(-10'sd512, -10'sd512);
    send_sample(-10'sd512, 10'sd511);
    send_sample(10'sd0,    10'sd511);
    send_sample(10'sd511,  -10'sd512);
    send_sample(-10'sd1,   10'sd0);
    in_valid <= 1'b0;
    wait_drained();

    // random phases under rotating settings
    while (sent < RANDOM_ITEMS) begin
      case (phase % 5)
        0:       program_cfg($urandom_range(0, 40), RUN_TOP);
        1:       program_cfg(0, $urandom_range(0, 15));
        2:       program_cfg($urandom_range(0, DZ_MAX), $urandom_range(1, 15));
        3:       program_cfg($urandom_range(150, 250), $urandom_range(1, 4));
        default: program_cfg(DZ_MAX, 1);
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 80);
      repeat (n) begin
        send_random_sample();
        sent++;
      end
      in_valid <= 1'b0;
      wait_drained();
      phase++;
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
